FILE: rtl/lcg_seed_inversion_tester_top_macros.svh
// Assertion macros shared by the seed inversion tester RTL.
// Depends on nothing; included by modules that carry assertions.
`ifndef LCG_SEED_INVERSION_TESTER_TOP_MACROS_SVH
`define LCG_SEED_INVERSION_TESTER_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define LSIT_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
`define LSIT_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define LSIT_ASSERT_IMP(label, clk, rstn, ante, cons)
`define LSIT_ASSERT_NXT(label, clk, rstn, ante, cons)
`endif
`endif

FILE: rtl/lsit_pkg.sv
// Package for the seed inversion tester: constants, register indexes, stage types.
// Depends on nothing.
`default_nettype none
package lsit_pkg;
    localparam int StateW = 48;
    localparam int Shift = 17;
    localparam logic [47:0] LcgMul = 48'h5_DEEC_E66D;
    localparam logic [47:0] LcgAdd = 48'hB;
    localparam logic [47:0] LcgInv = 48'hDFE0_5BCB_1365;
    localparam logic [63:0] RegXMul = 64'd341873128712;
    localparam logic [63:0] RegZMul = 64'd132897987541;
    localparam int PipeDepth = 6;
    // floor((2^32 - 1) / 24), the reciprocal for the reset chunk range.
    localparam logic [31:0] RecipReset = 32'd178956970;

    typedef enum logic [2:0] {
        REG_CHUNK_RANGE = 3'd0,
        REG_SALT        = 3'd1,
        REG_REGION_X    = 3'd2,
        REG_REGION_Z    = 3'd3,
        REG_OFFSET_X    = 3'd4,
        REG_OFFSET_Z    = 3'd5
    } reg_idx_t;

    // Settings seen by the datapath.
    typedef struct packed {
        logic [11:0] chunk_range;
        logic [11:0] offset_x;
        logic [11:0] offset_z;
        logic        cfg_ok;
        logic [47:0] seed_off;
        logic [31:0] recip;
    } cfg_t;

    // Pipeline flow control between the datapath and the skid stage.
    typedef struct packed {
        logic advance;
        logic out_valid;
    } flow_t;

    // Hi/lo partial products split a 48x48 multiply, kept mod 2^48, into two terms.
    function automatic logic [47:0] mul48(input logic [47:0] a, input logic [47:0] b);
        logic [47:0] lo;
        logic [47:0] hi;
        begin
            lo = 48'(a[23:0] * b);
            hi = 48'({a[47:24] * b[23:0], 24'd0});
            mul48 = lo + hi;
        end
    endfunction
endpackage
`default_nettype wire

FILE: rtl/lsit_cfg.sv
// Configuration registers, the precomputed region/salt offset and the range reciprocal.
// Depends on lsit_pkg.
`default_nettype none
module lsit_cfg (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         cfg_we,
    input  wire logic [2:0]   cfg_addr,
    input  wire logic [31:0]  cfg_wdata,
    output lsit_pkg::cfg_t    cfg
);
    import lsit_pkg::*;

    logic [11:0] range_reg, ox_reg, oz_reg;
    logic [31:0] salt_reg, rx_reg, rz_reg;
    logic [47:0] px_reg, pz_reg, off_reg;
    logic        ok_reg;
    logic [31:0] recip_reg;
    logic [11:0] prem_reg;
    logic [5:0]  dcnt_reg;
    logic [12:0] trial;
    logic        qbit;

    // Register writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            range_reg <= 12'd24;
            ox_reg    <= '0;
            oz_reg    <= '0;
            salt_reg  <= '0;
            rx_reg    <= '0;
            rz_reg    <= '0;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_CHUNK_RANGE: range_reg <= cfg_wdata[11:0];
                REG_SALT:        salt_reg  <= cfg_wdata;
                REG_REGION_X:    rx_reg    <= cfg_wdata;
                REG_REGION_Z:    rz_reg    <= cfg_wdata;
                REG_OFFSET_X:    ox_reg    <= cfg_wdata[11:0];
                REG_OFFSET_Z:    oz_reg    <= cfg_wdata[11:0];
                default: ;
            endcase
        end
    end

    // Offset products, registered before the sum, which is registered in turn.
    always_ff @(posedge aclk) begin
        px_reg  <= 48'($signed(rx_reg) * $signed(RegXMul[39:0]));
        pz_reg  <= 48'($signed(rz_reg) * $signed(RegZMul[38:0]));
        off_reg <= px_reg + pz_reg + {16'd0, salt_reg};
        ok_reg  <= ((range_reg & (range_reg - 12'd1)) != 12'd0)
                   && (ox_reg < range_reg) && (oz_reg < range_reg);
    end

    // Restoring division of an all-ones 32-bit dividend by the range, one
    // quotient bit per cycle; a range write restarts the 32 iterations.
    assign trial = {prem_reg, 1'b1};
    assign qbit  = (trial >= {1'b0, range_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            recip_reg <= RecipReset;
            prem_reg  <= '0;
            dcnt_reg  <= '0;
        end else if (cfg_we && (cfg_addr == REG_CHUNK_RANGE)) begin
            recip_reg <= '0;
            prem_reg  <= '0;
            dcnt_reg  <= 6'd32;
        end else if (dcnt_reg != 6'd0) begin
            recip_reg <= {recip_reg[30:0], qbit};
            prem_reg  <= qbit ? 12'(trial - {1'b0, range_reg}) : trial[11:0];
            dcnt_reg  <= dcnt_reg - 6'd1;
        end
    end

    assign cfg.chunk_range = range_reg;
    assign cfg.offset_x    = ox_reg;
    assign cfg.offset_z    = oz_reg;
    assign cfg.cfg_ok      = ok_reg;
    assign cfg.seed_off    = off_reg;
    assign cfg.recip       = recip_reg;
endmodule
`default_nettype wire

FILE: rtl/lsit_datapath.sv
// Six-stage candidate pipeline: build state, step forward, z draw remainder, step back.
// Depends on lsit_pkg and the assertion macro header.
`default_nettype none
`include "lcg_seed_inversion_tester_top_macros.svh"
module lsit_datapath (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  lsit_pkg::cfg_t    cfg,
    input  wire logic         in_valid,
    input  wire logic [29:0]  class_step,
    input  wire logic [16:0]  low_bits,
    input  wire logic         advance,
    output lsit_pkg::flow_t   flow,
    output logic              hit,
    output logic              in_range,
    output logic [47:0]       world_seed
);
    import lsit_pkg::*;

    logic [PipeDepth-1:0] v_reg;
    // Stage 1: u and s1.
    logic [42:0] u1_reg;
    logic [16:0] low1_reg;
    // Stage 2: forward step and back step partial products, low and high.
    logic [47:0] fwlo2_reg, fwhi2_reg, bklo2_reg, bkhi2_reg;
    logic        inr2_reg;
    // Stage 3: s2 and back product.
    logic [47:0] s3_reg, bk3_reg;
    logic        inr3_reg;
    // Stage 4: quotient estimate by reciprocal.
    logic [30:0] draw4_reg;
    logic [30:0] q4_reg;
    logic [47:0] bk4_reg;
    logic        inr4_reg;
    // Stage 5: quotient times range, from which the remainder is formed.
    logic [42:0] qr5_reg;
    logic [30:0] draw5_reg;
    logic [47:0] bk5_reg;
    logic        inr5_reg;
    // Stage 6: result.
    logic        hit6_reg, inr6_reg;
    logic [47:0] seed6_reg;

    logic [47:0] s1, sb;
    logic [42:0] u_full;
    logic [31:0] rem_a, rem_b;
    logic [30:0] rem;

    assign u_full = 43'(cfg.offset_x) + 43'(class_step) * 43'(cfg.chunk_range);
    assign s1 = {u1_reg[30:0], low1_reg};
    assign sb = s1 - LcgAdd;
    // The reciprocal floor((2^32 - 1) / r) never overshoots; the quotient is low
    // by at most one, so the conditional subtracts bring the remainder below r.
    assign rem_a = 32'(draw5_reg) - 32'(qr5_reg[30:0]);
    assign rem_b = (rem_a >= 32'(cfg.chunk_range)) ? rem_a - 32'(cfg.chunk_range) : rem_a;
    assign rem = (rem_b >= 32'(cfg.chunk_range)) ? 31'(rem_b - 32'(cfg.chunk_range))
                                                 : rem_b[30:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (advance) begin
            v_reg <= {v_reg[PipeDepth-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            u1_reg    <= u_full;
            low1_reg  <= low_bits;
            inr2_reg  <= (u1_reg < 43'h8000_0000);
            fwlo2_reg <= 48'(s1[23:0] * LcgMul);
            fwhi2_reg <= 48'({s1[47:24] * LcgMul[23:0], 24'd0});
            bklo2_reg <= 48'(sb[23:0] * LcgInv);
            bkhi2_reg <= 48'({sb[47:24] * LcgInv[23:0], 24'd0});
            s3_reg    <= fwlo2_reg + fwhi2_reg + LcgAdd;
            bk3_reg   <= bklo2_reg + bkhi2_reg;
            inr3_reg  <= inr2_reg;
            draw4_reg <= s3_reg[47:17];
            q4_reg    <= 31'((63'(s3_reg[47:17]) * 63'(cfg.recip)) >> 32);
            bk4_reg   <= bk3_reg ^ LcgMul;
            inr4_reg  <= inr3_reg;
            qr5_reg   <= 43'(q4_reg) * 43'(cfg.chunk_range);
            draw5_reg <= draw4_reg;
            bk5_reg   <= bk4_reg - cfg.seed_off;
            inr5_reg  <= inr4_reg;
            hit6_reg  <= inr5_reg && cfg.cfg_ok && (rem == 31'(cfg.offset_z));
            inr6_reg  <= inr5_reg;
            seed6_reg <= (inr5_reg && cfg.cfg_ok && (rem == 31'(cfg.offset_z))) ? bk5_reg
                                                                               : 48'd0;
        end
    end

    assign flow.advance   = advance;
    assign flow.out_valid = v_reg[PipeDepth-1];
    assign hit        = hit6_reg;
    assign in_range   = inr6_reg;
    assign world_seed = seed6_reg;

    `LSIT_ASSERT_IMP(a_seed_zero, aclk, aresetn, v_reg[PipeDepth-1] && !hit6_reg, seed6_reg == 48'd0)
    `LSIT_ASSERT_IMP(a_hit_inr, aclk, aresetn, v_reg[PipeDepth-1] && hit6_reg, inr6_reg)
    `LSIT_ASSERT_NXT(a_hold, aclk, aresetn, !advance, v_reg == $past(v_reg))
endmodule
`default_nettype wire

FILE: rtl/lsit_skid.sv
// Output skid stage that decouples the pipeline from the result channel.
// Depends on lsit_pkg.
`default_nettype none
module lsit_skid (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  lsit_pkg::flow_t  flow,
    input  wire logic [49:0] pipe_data,
    output logic             advance,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [49:0]      m_data
);
    import lsit_pkg::*;

    logic        mv_reg, sv_reg;
    logic [49:0] md_reg, sd_reg;
    logic        push;

    // The pipeline moves whenever the spare slot is empty.
    assign advance = !sv_reg;
    assign push    = advance && flow.out_valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mv_reg <= 1'b0;
            sv_reg <= 1'b0;
        end else begin
            if (!mv_reg || m_tready) begin
                mv_reg <= sv_reg || push;
            end else if (push) begin
                sv_reg <= 1'b1;
            end
            if ((!mv_reg || m_tready) && sv_reg) begin
                sv_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!mv_reg || m_tready) begin
            md_reg <= sv_reg ? sd_reg : pipe_data;
        end else if (push) begin
            sd_reg <= pipe_data;
        end
    end

    assign m_tvalid = mv_reg;
    assign m_data   = md_reg;
endmodule
`default_nettype wire

FILE: rtl/lcg_seed_inversion_tester_top.sv
// One item per cycle; a result passes the datapath stages, then the skid output register.
// The six-stage datapath stalls only when the output skid slot is occupied.
// Reset (synchronous, aresetn low) empties the pipeline and restores registers.
// Written settings reach the datapath through registers; a chunk_range write also
// reruns the bit-serial reciprocal update.
`default_nettype none
module lcg_seed_inversion_tester_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,  // class_step[29:0], low_bits[46:30], zero pad
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [55:0]      m_tdata,  // hit[0], in_range[1], world_seed[49:2], zero pad
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_addr,
    input  wire logic [31:0] cfg_wdata
);
    import lsit_pkg::*;

    cfg_t        cfg;
    flow_t       flow;
    logic        advance, hit, in_range;
    logic [47:0] world_seed;
    logic [49:0] m_data;

    lsit_cfg u_cfg (.aclk, .aresetn, .cfg_we, .cfg_addr, .cfg_wdata, .cfg);

    lsit_datapath u_dp (
        .aclk, .aresetn, .cfg,
        .in_valid(s_tvalid && advance),
        .class_step(s_tdata[29:0]), .low_bits(s_tdata[46:30]),
        .advance, .flow, .hit, .in_range, .world_seed
    );

    lsit_skid u_skid (
        .aclk, .aresetn, .flow,
        .pipe_data({world_seed, in_range, hit}),
        .advance, .m_tvalid, .m_tready, .m_data
    );

    assign s_tready = advance;
    assign m_tdata  = {6'd0, m_data};
endmodule
`default_nettype wire

FILE: tb/tb_lcg_seed_inversion_tester_top.sv
// Testbench for the seed inversion tester: drives candidates over the input stream,
// predicts hit, range flag and world seed, and checks every result transaction.
// Depends on lsit_pkg and lcg_seed_inversion_tester_top.
`default_nettype none

// Holds the current settings and the queue of predicted results.
class seed_scoreboard;
    logic [11:0] chunk_range = 12'd24;
    logic [31:0] salt = '0;
    logic [31:0] region_x = '0;
    logic [31:0] region_z = '0;
    logic [11:0] offset_x = '0;
    logic [11:0] offset_z = '0;
    logic [49:0] pending[$];
    int errors = 0;

    function void set_reg(lsit_pkg::reg_idx_t idx, logic [31:0] v);
        case (idx)
            lsit_pkg::REG_CHUNK_RANGE: chunk_range = v[11:0];
            lsit_pkg::REG_SALT:        salt = v;
            lsit_pkg::REG_REGION_X:    region_x = v;
            lsit_pkg::REG_REGION_Z:    region_z = v;
            lsit_pkg::REG_OFFSET_X:    offset_x = v[11:0];
            lsit_pkg::REG_OFFSET_Z:    offset_z = v[11:0];
            default: ;
        endcase
    endfunction

    // Predicts one candidate test and queues the result.
    function void note_candidate(logic [29:0] k, logic [16:0] low);
        logic [63:0] u, r, s1, s2, draw, off, back, inv, seed;
        logic hit, in_rng, ok;
        r = {52'd0, chunk_range};
        u = {52'd0, offset_x} + {34'd0, k} * r;
        in_rng = u < 64'h8000_0000;
        ok = in_rng && ((r & (r - 1)) != 0) && offset_x < chunk_range
            && offset_z < chunk_range;
        hit = 1'b0;
        seed = '0;
        if (ok) begin
            s1 = ((u << 17) | {47'd0, low}) & 64'hFFFF_FFFF_FFFF;
            s2 = (s1 * 64'h5_DEEC_E66D + 64'hB) & 64'hFFFF_FFFF_FFFF;
            draw = (s2 >> 17) & 64'hFFFF_FFFF;
            if (draw % r == {52'd0, offset_z}) begin
                // Inverse of the multiplier mod 2^48 by Newton iteration.
                inv = 64'd1;
                for (int i = 0; i < 6; i++) inv = inv * (64'd2 - 64'h5_DEEC_E66D * inv);
                back = ((s1 - 64'hB) * inv) & 64'hFFFF_FFFF_FFFF;
                off = {{32{region_x[31]}}, region_x} * 64'd341873128712
                    + {{32{region_z[31]}}, region_z} * 64'd132897987541
                    + {32'd0, salt};
                seed = ((back ^ 64'h5_DEEC_E66D) - off) & 64'hFFFF_FFFF_FFFF;
                hit = 1'b1;
            end
        end
        pending.push_back({seed[47:0], in_rng, hit});
    endfunction

    function void check_result(logic [55:0] d);
        logic [49:0] e;
        if (pending.size() == 0) begin
            $error("result transaction with no expectation: %h", d);
            errors++;
            return;
        end
        e = pending.pop_front();
        if (d[0] !== e[0]) begin
            $error("hit: expected %0d actual %0d", e[0], d[0]);
            errors++;
        end
        if (d[1] !== e[1]) begin
            $error("in_range: expected %0d actual %0d", e[1], d[1]);
            errors++;
        end
        if (d[49:2] !== e[49:2]) begin
            $error("world_seed: expected %h actual %h", e[49:2], d[49:2]);
            errors++;
        end
        if (d[55:50] !== 6'd0) begin
            $error("pad: expected 0 actual %h", d[55:50]);
            errors++;
        end
    endfunction
endclass

module tb_lcg_seed_inversion_tester_top;
    import lsit_pkg::*;

    localparam int WatchdogLimit = 20000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_addr = '0;
    logic [31:0] cfg_wdata = '0;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    bit hold_off = 1'b0;
    int idle_cycles = 0;

    seed_scoreboard sb = new();

    lcg_seed_inversion_tester_top uut (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Receiver: random stalls plus an optional long hold-off.
    always @(posedge aclk) begin
        if (m_tvalid && m_tready) sb.check_result(m_tdata);
        m_tready <= aresetn && !hold_off && ($urandom_range(99) >= recv_stall_pct);
    end

    // Watchdog on cycles without any accepted transaction.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WatchdogLimit) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Stops offering and waits until every expected result has arrived.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (12) @(posedge aclk);
    endtask

    // Writes one register once the block is empty.
    task automatic write_reg(reg_idx_t idx, logic [31:0] v);
        drain();
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we <= 1'b0;
        sb.set_reg(idx, v);
        // A range write reruns the reciprocal update, so every write is followed by a wait.
        repeat (40) @(posedge aclk);
    endtask

    // Offers one candidate and waits for its transaction.
    task automatic send_candidate(logic [29:0] k, logic [16:0] low);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {1'b0, low, k};
        do @(posedge aclk); while (!s_tready);
        sb.note_candidate(k, low);
    endtask

    // Random candidates; small class steps keep u in range most of the time.
    task automatic random_burst(int n);
        logic [29:0] k;
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(3))
                0: k = 30'($urandom);
                1: k = 30'(30'h3FFF_FFFF - $urandom_range(3));
                default: k = 30'($urandom_range(1 << 19));
            endcase
            send_candidate(k, 17'($urandom));
        end
    endtask

    task automatic random_settings();
        logic [11:0] r;
        r = 12'($urandom_range(2, 60));
        if ($urandom_range(3) == 0) r = 12'($urandom_range(2, 4095));
        write_reg(REG_CHUNK_RANGE, 32'(r));
        write_reg(REG_SALT, $urandom);
        write_reg(REG_REGION_X, $urandom);
        write_reg(REG_REGION_Z, $urandom);
        write_reg(REG_OFFSET_X, 32'(($urandom_range(9) == 0) ? r : $urandom_range(r - 1)));
        write_reg(REG_OFFSET_Z, 32'(($urandom_range(9) == 0) ? r : $urandom_range(r - 1)));
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: reset settings, then field extremes.
        send_candidate('0, '0);
        send_candidate(30'h3FFF_FFFF, 17'h1FFFF);
        send_candidate(30'd89478485, 17'h1FFFF);
        send_candidate(30'd89478486, 17'd0);
        for (int i = 0; i < 24; i++) send_candidate(30'(i), 17'(i * 5461));
        drain();

        // Extremes of the settings; a power-of-two range and offsets out of range.
        write_reg(REG_CHUNK_RANGE, 32'd4095);
        write_reg(REG_SALT, 32'hFFFF_FFFF);
        write_reg(REG_REGION_X, 32'h8000_0000);
        write_reg(REG_REGION_Z, 32'h7FFF_FFFF);
        write_reg(REG_OFFSET_X, 32'd4094);
        write_reg(REG_OFFSET_Z, 32'd4094);
        random_burst(8);
        drain();
        write_reg(REG_CHUNK_RANGE, 32'd2);
        write_reg(REG_OFFSET_X, 32'd0);
        write_reg(REG_OFFSET_Z, 32'd0);
        random_burst(4);
        write_reg(REG_CHUNK_RANGE, 32'd3);
        write_reg(REG_OFFSET_X, 32'd2);
        write_reg(REG_OFFSET_Z, 32'd1);
        random_burst(6);
        write_reg(REG_OFFSET_Z, 32'd3);
        random_burst(3);
        drain();

        // Random phases with differing idle patterns.
        for (int ph = 0; ph < 8; ph++) begin
            random_settings();
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 61; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 61; end
                default: begin send_idle_pct = 32; recv_stall_pct = 32; end
            endcase
            if (ph == 4) begin
                fork
                    begin
                        hold_off = 1'b1;
                        repeat (60) @(posedge aclk);
                        hold_off = 1'b0;
                    end
                    random_burst(120);
                join
            end else begin
                random_burst(120);
            end
            drain();
        end

        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end
endmodule
`default_nettype wire
